### rtl/scfp_pkg.sv
package scfp_pkg;

    // Command prefix, first character in the top byte
    localparam int unsigned PREFIX_LEN = 11;
    localparam logic [8*PREFIX_LEN-1:0] PFX_SET_STR  = "##SRVO:PWMS";
    localparam logic [8*PREFIX_LEN-1:0] PFX_INIT_STR = "##SRVO:INIT";

    // Characters of interest
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Frame kinds
    localparam logic [1:0] KIND_SET     = 2'd0;
    localparam logic [1:0] KIND_INIT    = 2'd1;
    localparam logic [1:0] KIND_NOPAREN = 2'd2;
    localparam logic [1:0] KIND_UNKNOWN = 2'd3;

    // Magnitude clamp: one past the largest positive value
    localparam logic [15:0] MAG_LIMIT = 16'h8000;
    localparam logic [15:0] POS_MAX   = 16'h7FFF;

    typedef logic signed [15:0] arg_t;

    // Pick character idx (0 = first) of a prefix string
    function automatic logic [7:0] pfx_byte(input logic [8*PREFIX_LEN-1:0] str,
                                            input logic [3:0] idx);
        logic [7:0] res;
        res = 8'h00;
        for (int i = 0; i < PREFIX_LEN; i++) begin
            if (idx == 4'(i)) begin
                res = str[8*(PREFIX_LEN-1-i) +: 8];
            end
        end
        return res;
    endfunction

    // Signed, saturated value of a parsed argument
    function automatic arg_t arg_value(input logic neg, input logic [15:0] mag);
        arg_t res;
        if (neg) begin
            res = arg_t'(16'(~mag + 16'd1));
        end else if (mag > POS_MAX) begin
            res = arg_t'(POS_MAX);
        end else begin
            res = arg_t'(mag);
        end
        return res;
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

endpackage

### rtl/scfp_ram.sv
module scfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/servo_command_frame_parser.sv
// Servo command frame parser.
// s_ channel: one received serial byte per request in s_tdata[7:0].
// m_ channel: one result per complete frame, m_tdata holds the frame kind
// and the four saturated arguments.
// A frame completes when '&' arrives and the buffer starts with "##". Bytes
// are written into a byte buffer RAM; bytes arriving with the buffer full
// are dropped. After an ordinary byte s_tready stays high for the next one.
// A completing '&' starts a walk that reads the stored bytes (up to
// BUFFER_DEPTH) through the RAM's single read port, one byte per cycle;
// the block stays busy (s_tready low) through the walk and until the
// result is loaded into the output register, when s_tready rises again.
// The output register holds one result; while it waits for m_tready the
// block keeps taking bytes, and only a following frame end waits for it.
// Reset empties the buffer at once (no clearing pass) and drops any
// pending result. A stall on m_ only delays the next completed frame.
module servo_command_frame_parser #(
    parameter int BUFFER_DEPTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] frame_kind, [17:2] front_left, [33:18] rear_left,
    // [49:34] front_right, [65:50] rear_right, [71:66] zero
    output logic [71:0] m_tdata
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = $clog2(BUFFER_DEPTH + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam logic [1:0] PH_LEAD  = 2'd0;
    localparam logic [1:0] PH_DIGIT = 2'd1;
    localparam logic [1:0] PH_END   = 2'd2;

    localparam logic [CW-1:0] PFX_N  = CW'(scfp_pkg::PREFIX_LEN);
    localparam logic [CW-1:0] BODY_0 = CW'(scfp_pkg::PREFIX_LEN + 1);

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          hash0_reg, hash0_next;
    logic          hash1_reg, hash1_next;
    logic [7:0]    last_reg, last_next;
    logic [7:0]    prev_reg, prev_next;

    logic [CW-1:0] walk_cnt_reg, walk_cnt_next;
    logic [CW-1:0] len_reg, len_next;
    logic [CW-1:0] end_reg, end_next;
    logic          close_ok_reg, close_ok_next;
    logic          open_ok_reg, open_ok_next;
    logic          set_ok_reg, set_ok_next;
    logic          init_ok_reg, init_ok_next;
    logic [CW-1:0] issue_reg, issue_next;
    logic          rd_vld_reg, rd_vld_next;
    logic [CW-1:0] pos_reg, pos_next;

    logic [2:0]    arg_k_reg, arg_k_next;
    logic [1:0]    phase_reg, phase_next;
    logic          neg_reg, neg_next;
    logic [15:0]   mag_reg, mag_next;
    scfp_pkg::arg_t args_reg [4];
    scfp_pkg::arg_t args_next [4];

    logic          m_tvalid_reg, m_tvalid_next;
    logic [71:0]   m_tdata_reg, m_tdata_next;

    logic          ram_we;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    logic          s_acc;
    logic          full;
    logic          store;
    logic [CW-1:0] count_after;
    logic [7:0]    byte_b;
    logic [19:0]   mag_acc;
    logic [1:0]    kind;
    logic          parse_ok;
    logic          args_ok;
    logic          walk_end;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign full     = (count_reg == CW'(BUFFER_DEPTH));
    assign store    = s_acc && !full;
    assign ram_we   = store;
    assign count_after = count_reg + CW'(!full);
    assign ram_raddr = issue_reg[AW-1:0];
    assign byte_b    = ram_rdata;
    assign walk_end  = (state_reg == ST_WALK) && (issue_reg == walk_cnt_reg) && !rd_vld_reg;

    scfp_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_buf (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (s_tdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Classify the finished frame
    always_comb begin
        if (len_reg >= PFX_N && set_ok_reg) begin
            kind = scfp_pkg::KIND_SET;
        end else if (len_reg >= PFX_N && init_ok_reg) begin
            kind = scfp_pkg::KIND_INIT;
        end else begin
            kind = scfp_pkg::KIND_UNKNOWN;
        end
        parse_ok = (len_reg > PFX_N) && open_ok_reg && close_ok_reg;
        if (kind != scfp_pkg::KIND_UNKNOWN && !parse_ok) begin
            kind = scfp_pkg::KIND_NOPAREN;
        end
        // Arguments are reported only for a known, parenthesized command
        args_ok = (kind == scfp_pkg::KIND_SET) || (kind == scfp_pkg::KIND_INIT);
    end

    assign mag_acc = {mag_reg, 3'b000} + {3'b000, mag_reg, 1'b0}
                   + {12'd0, byte_b - scfp_pkg::CH_ZERO};

    always_comb begin
        logic          is_frame;
        logic          h0;
        logic          h1;
        logic [CW-1:0] len_v;
        logic          keep;
        state_next    = state_reg;
        count_next    = count_reg;
        hash0_next    = hash0_reg;
        hash1_next    = hash1_reg;
        last_next     = last_reg;
        prev_next     = prev_reg;
        walk_cnt_next = walk_cnt_reg;
        len_next      = len_reg;
        end_next      = end_reg;
        close_ok_next = close_ok_reg;
        open_ok_next  = open_ok_reg;
        set_ok_next   = set_ok_reg;
        init_ok_next  = init_ok_reg;
        issue_next    = issue_reg;
        rd_vld_next   = 1'b0;
        pos_next      = issue_reg;
        arg_k_next    = arg_k_reg;
        phase_next    = phase_reg;
        neg_next      = neg_reg;
        mag_next      = mag_reg;
        args_next     = args_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        is_frame      = 1'b0;
        h0            = hash0_reg;
        h1            = hash1_reg;
        len_v         = count_after;
        keep          = 1'b0;

        // Release the output register
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    // Track the first two bytes and the last two stored
                    if (store) begin
                        last_next = s_tdata;
                        prev_next = last_reg;
                        if (count_reg == '0) begin
                            h0 = (s_tdata == scfp_pkg::CH_HASH);
                        end
                        if (count_reg == CW'(1)) begin
                            h1 = (s_tdata == scfp_pkg::CH_HASH);
                        end
                    end
                    hash0_next = h0;
                    hash1_next = h1;
                    is_frame = (s_tdata == scfp_pkg::CH_AMP) && (count_after >= CW'(2))
                             && h0 && h1;
                    count_next = count_after;
                    if (is_frame) begin
                        // Strip a stored '&' and note the closing byte
                        if (last_next == scfp_pkg::CH_AMP) begin
                            len_v = count_after - CW'(1);
                            close_ok_next = (prev_next == scfp_pkg::CH_CLOSE);
                        end else begin
                            close_ok_next = (last_next == scfp_pkg::CH_CLOSE);
                        end
                        len_next      = len_v;
                        end_next      = len_v - CW'(1);
                        walk_cnt_next = count_after;
                        count_next    = '0;
                        issue_next    = '0;
                        set_ok_next   = 1'b1;
                        init_ok_next  = 1'b1;
                        open_ok_next  = 1'b0;
                        arg_k_next    = '0;
                        phase_next    = PH_LEAD;
                        neg_next      = 1'b0;
                        mag_next      = '0;
                        for (int i = 0; i < 4; i++) begin
                            args_next[i] = '0;
                        end
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                // Issue one buffer read per cycle
                if (issue_reg != walk_cnt_reg) begin
                    rd_vld_next = 1'b1;
                    issue_next  = issue_reg + CW'(1);
                end
                // Consume the returning byte
                if (rd_vld_reg) begin
                    if (pos_reg < PFX_N) begin
                        if (byte_b != scfp_pkg::pfx_byte(scfp_pkg::PFX_SET_STR, pos_reg[3:0]))
                        begin
                            set_ok_next = 1'b0;
                        end
                        if (byte_b != scfp_pkg::pfx_byte(scfp_pkg::PFX_INIT_STR, pos_reg[3:0]))
                        begin
                            init_ok_next = 1'b0;
                        end
                    end
                    if (pos_reg == PFX_N) begin
                        open_ok_next = (byte_b == scfp_pkg::CH_OPEN);
                    end
                    if (pos_reg >= BODY_0 && pos_reg < end_reg && arg_k_reg < 3'd4) begin
                        if (byte_b == scfp_pkg::CH_COMMA) begin
                            args_next[arg_k_reg[1:0]] = scfp_pkg::arg_value(neg_reg, mag_reg);
                            arg_k_next = arg_k_reg + 3'd1;
                            phase_next = PH_LEAD;
                            neg_next   = 1'b0;
                            mag_next   = '0;
                        end else begin
                            case (phase_reg)
                                PH_LEAD: begin
                                    if (scfp_pkg::is_space(byte_b)) begin
                                        keep = 1'b1;
                                    end else if (byte_b == scfp_pkg::CH_MINUS) begin
                                        neg_next   = 1'b1;
                                        phase_next = PH_DIGIT;
                                    end else if (byte_b == scfp_pkg::CH_PLUS) begin
                                        phase_next = PH_DIGIT;
                                    end else if (scfp_pkg::is_digit(byte_b)) begin
                                        mag_next   = 16'(mag_acc);
                                        phase_next = PH_DIGIT;
                                    end else begin
                                        phase_next = PH_END;
                                    end
                                end
                                PH_DIGIT: begin
                                    if (scfp_pkg::is_digit(byte_b)) begin
                                        if (mag_acc > {4'd0, scfp_pkg::MAG_LIMIT}) begin
                                            mag_next = scfp_pkg::MAG_LIMIT;
                                        end else begin
                                            mag_next = 16'(mag_acc);
                                        end
                                    end else begin
                                        phase_next = PH_END;
                                    end
                                end
                                default: begin
                                    keep = 1'b1;
                                end
                            endcase
                        end
                    end
                end
                // Close the open argument at the end of the walk
                if (walk_end) begin
                    if (arg_k_reg < 3'd4) begin
                        args_next[arg_k_reg[1:0]] = scfp_pkg::arg_value(neg_reg, mag_reg);
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // Load the result once the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {6'd0,
                                     args_ok ? args_reg[3] : 16'sd0,
                                     args_ok ? args_reg[2] : 16'sd0,
                                     args_ok ? args_reg[1] : 16'sd0,
                                     args_ok ? args_reg[0] : 16'sd0,
                                     kind};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (keep) begin
            phase_next = phase_reg;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            hash0_reg    <= 1'b0;
            hash1_reg    <= 1'b0;
            issue_reg    <= '0;
            rd_vld_reg   <= 1'b0;
            arg_k_reg    <= '0;
            phase_reg    <= PH_LEAD;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            hash0_reg    <= hash0_next;
            hash1_reg    <= hash1_next;
            issue_reg    <= issue_next;
            rd_vld_reg   <= rd_vld_next;
            arg_k_reg    <= arg_k_next;
            phase_reg    <= phase_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload and walk bookkeeping
    always_ff @(posedge aclk) begin
        last_reg     <= last_next;
        prev_reg     <= prev_next;
        walk_cnt_reg <= walk_cnt_next;
        len_reg      <= len_next;
        end_reg      <= end_next;
        close_ok_reg <= close_ok_next;
        open_ok_reg  <= open_ok_next;
        set_ok_reg   <= set_ok_next;
        init_ok_reg  <= init_ok_next;
        pos_reg      <= pos_next;
        neg_reg      <= neg_next;
        mag_reg      <= mag_next;
        args_reg     <= args_next;
        m_tdata_reg  <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(BUFFER_DEPTH))
        else $error("byte count beyond buffer depth");

    a_arg_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        arg_k_reg <= 3'd4)
        else $error("argument index beyond four");

    a_read_in_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_vld_reg |-> (state_reg == ST_WALK))
        else $error("buffer read returned outside the walk");

    a_done_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && (!m_tvalid_reg || m_tready))
            |=> (m_tvalid_reg && state_reg == ST_IDLE))
        else $error("finished frame did not reach the output register");

endmodule
